FILE: rtl/scf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants
// Word layouts, scancode constants and the command that passes from the
// decoder front end to the character FIFO back end.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam int unsigned IN_DATA_W    = 24;
  localparam int unsigned OUT_DATA_W   = 24;
  localparam int unsigned USER_W       = 2;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned CODE_W       = 7;
  localparam int unsigned KEYMAP_DEPTH = 256;
  localparam int unsigned KEYMAP_AW    = 8;
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef enum logic [1:0] {
    KIND_SCAN  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  localparam logic [CODE_W-1:0] SCAN_SHIFT_LEFT  = 7'h2A;
  localparam logic [CODE_W-1:0] SCAN_SHIFT_RIGHT = 7'h36;
  localparam logic [CODE_W-1:0] SCAN_ENTER       = 7'h1C;
  localparam logic [CODE_W-1:0] SCAN_BACKSPACE   = 7'h0E;
  localparam logic [CODE_W-1:0] SCAN_SPACE       = 7'h39;

  localparam logic [CHAR_W-1:0] CH_ENTER     = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [7:0]        SHIFT_MAX    = 8'hFF;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic              dropped;
    logic              produced_valid;
    logic [CHAR_W-1:0] produced_char;
    logic              read_valid;
    logic [CHAR_W-1:0] read_char;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/scf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_ram: generic memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/scf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_front: scancode decoder front end
// Accepts words, tracks the shift counter, owns the keymap memory and turns
// each word into a FIFO command in the cycle after it is accepted, once the
// registered keymap read has returned.
// ----------------------------------------------------------------------------
module scf_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_valid_i,
  output logic                              s_ready_o,
  input  wire logic [scf_pkg::USER_W-1:0]   kind_i,
  input  wire logic [7:0]                   scan_code_i,
  input  wire logic                         upper_select_i,
  input  wire logic [scf_pkg::CHAR_W-1:0]   entry_char_i,
  output logic                              cmd_valid_o,
  input  wire logic                         cmd_ready_i,
  output scf_pkg::cmd_t                     cmd_o
);
  import scf_pkg::*;

  typedef enum logic [1:0] {
    CL_NONE,
    CL_POP,
    CL_FIXED,
    CL_TABLE
  } class_e;

  logic                    acc;
  logic [CODE_W-1:0]       code;
  logic                    is_rel;
  logic                    is_shift;
  logic [7:0]              shift_d, shift_q;
  class_e                  cls_d, cls_q;
  logic [CHAR_W-1:0]       fixed_d, fixed_q;
  logic                    hit_d, hit_q;
  logic                    b_valid_d, b_valid_q;
  logic [KEYMAP_AW-1:0]    km_addr;
  logic                    km_we, km_re;
  logic [CHAR_W-1:0]       km_rdata;
  logic [CHAR_W-1:0]       table_ch;
  logic [KEYMAP_DEPTH-1:0] km_vld_d, km_vld_q;

  assign s_ready_o   = !b_valid_q || cmd_ready_i;
  assign acc         = s_valid_i && s_ready_o;
  assign code        = scan_code_i[CODE_W-1:0];
  assign is_rel      = scan_code_i[7];
  assign is_shift    = (code == SCAN_SHIFT_LEFT) || (code == SCAN_SHIFT_RIGHT);
  assign cmd_valid_o = b_valid_q;
  assign b_valid_d   = acc || (b_valid_q && !cmd_ready_i);

  always_comb begin
    shift_d = shift_q;
    cls_d   = CL_NONE;
    fixed_d = '0;
    km_we   = 1'b0;
    km_re   = 1'b0;
    km_addr = {upper_select_i, code};
    case (kind_e'(kind_i))
      KIND_SCAN: begin
        if (is_rel) begin
          if (is_shift && (shift_q != '0)) begin
            shift_d = shift_q - 8'd1;
          end
        end else if (is_shift) begin
          if (shift_q != SHIFT_MAX) begin
            shift_d = shift_q + 8'd1;
          end
        end else begin
          case (code)
            SCAN_ENTER: begin
              cls_d   = CL_FIXED;
              fixed_d = CH_ENTER;
            end
            SCAN_BACKSPACE: begin
              cls_d   = CL_FIXED;
              fixed_d = CH_BACKSPACE;
            end
            SCAN_SPACE: begin
              cls_d   = CL_FIXED;
              fixed_d = CH_SPACE;
            end
            default: begin
              cls_d   = CL_TABLE;
              km_re   = acc;
              km_addr = {(shift_q != '0), code};
            end
          endcase
        end
      end
      KIND_READ: begin
        cls_d = CL_POP;
      end
      KIND_WRITE: begin
        km_we = acc && !is_rel;
      end
      default: begin
      end
    endcase
    hit_d    = km_vld_q[km_addr];
    km_vld_d = km_vld_q;
    if (km_we) begin
      km_vld_d[km_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      shift_q   <= '0;
      km_vld_q  <= '0;
    end else begin
      b_valid_q <= b_valid_d;
      km_vld_q  <= km_vld_d;
      if (acc) begin
        shift_q <= shift_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cls_q   <= cls_d;
      fixed_q <= fixed_d;
      hit_q   <= hit_d;
    end
  end

  scf_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(KEYMAP_DEPTH)
  ) u_keymap (
    .clk_i  (clk_i),
    .we_i   (km_we),
    .waddr_i(km_addr),
    .wdata_i(entry_char_i),
    .re_i   (km_re),
    .raddr_i(km_addr),
    .rdata_o(km_rdata)
  );

  assign table_ch = hit_q ? km_rdata : '0;

  always_comb begin
    cmd_o.op = OP_NONE;
    cmd_o.ch = '0;
    case (cls_q)
      CL_POP: begin
        cmd_o.op = OP_POP;
      end
      CL_FIXED: begin
        cmd_o.op = OP_PUSH;
        cmd_o.ch = fixed_q;
      end
      CL_TABLE: begin
        cmd_o.op = (table_ch != '0) ? OP_PUSH : OP_NONE;
        cmd_o.ch = table_ch;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/scf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_queue: command queue
// A short register queue that lets the decoder and the FIFO stall apart.
// ----------------------------------------------------------------------------
module scf_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire scf_pkg::cmd_t in_cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output scf_pkg::cmd_t      out_cmd_o
);
  import scf_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          ent_q [QUEUE_DEPTH];
  logic [PW-1:0] rd_ptr_q, wr_ptr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign in_ready_o  = cnt_q != CW'(QUEUE_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_cmd_o   = ent_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign cnt_d       = cnt_q + CW'(push) - CW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_back: character FIFO back end
// Executes push and pop commands on the ring buffer and holds each result
// word in an output register.
// ----------------------------------------------------------------------------
module scf_back #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire scf_pkg::cmd_t cmd_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output scf_pkg::result_t   res_o
);
  import scf_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

  logic [PW-1:0]     wp_d, wp_q, rp_d, rp_q;
  logic [PW-1:0]     wp_nxt, rp_nxt;
  logic              take, full, empty;
  logic              st_we, st_re;
  logic [CHAR_W-1:0] st_rdata;
  logic              o_valid_q;
  logic              rvalid_d, rvalid_q;
  logic [CHAR_W-1:0] pchar_d, pchar_q;
  logic              pvalid_d, pvalid_q;
  logic              drop_d, drop_q;

  assign cmd_ready_o = !o_valid_q || res_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign wp_nxt      = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
  assign rp_nxt      = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
  assign full        = wp_nxt == rp_q;
  assign empty       = wp_q == rp_q;

  always_comb begin
    st_we    = 1'b0;
    st_re    = 1'b0;
    wp_d     = wp_q;
    rp_d     = rp_q;
    rvalid_d = 1'b0;
    pchar_d  = '0;
    pvalid_d = 1'b0;
    drop_d   = 1'b0;
    case (cmd_i.op)
      OP_PUSH: begin
        pchar_d  = cmd_i.ch;
        pvalid_d = 1'b1;
        drop_d   = full;
        if (!full) begin
          st_we = take;
          wp_d  = wp_nxt;
        end
      end
      OP_POP: begin
        if (!empty) begin
          st_re    = take;
          rp_d     = rp_nxt;
          rvalid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      wp_q      <= '0;
      rp_q      <= '0;
    end else begin
      o_valid_q <= take || (o_valid_q && !res_ready_i);
      if (take) begin
        wp_q <= wp_d;
        rp_q <= rp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rvalid_q <= rvalid_d;
      pchar_q  <= pchar_d;
      pvalid_q <= pvalid_d;
      drop_q   <= drop_d;
    end
  end

  scf_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(FIFO_DEPTH)
  ) u_char_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(wp_q),
    .wdata_i(cmd_i.ch),
    .re_i   (st_re),
    .raddr_i(rp_q),
    .rdata_o(st_rdata)
  );

  assign res_valid_o          = o_valid_q;
  assign res_o.read_char      = rvalid_q ? st_rdata : '0;
  assign res_o.read_valid     = rvalid_q;
  assign res_o.produced_char  = pchar_q;
  assign res_o.produced_valid = pvalid_q;
  assign res_o.dropped        = drop_q;

endmodule
`default_nettype wire

FILE: rtl/scancode_to_char_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_to_char_fifo: set-1 scancode decoder with character FIFO
// Decodes keyboard scancodes through loadable keymaps into a ring FIFO and
// serves character reads, one result word per input word.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle when the output does not stall,
// and returns exactly one result word for each, in order. A result word passes
// the decoder register, which takes the registered keymap read, then the
// command queue, and then the FIFO stage, whose output register takes the
// registered character store read.
// A four-entry command queue sits between the decoder and
// the FIFO, so either side may stall without blocking the other. Keymaps
// read as zero after reset until their entries are written; the FIFO holds
// FIFO_DEPTH - 1 characters.
module scancode_to_char_fifo #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // scan_code[7:0], upper_select[8], entry_char[16:9], zero[23:17]
  input  wire logic [scf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[1:0]
  input  wire logic [scf_pkg::USER_W-1:0]       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // read_char[7:0], read_valid[8], produced_char[16:9], produced_valid[17],
  // dropped[18], zero[23:19]
  output logic      [scf_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import scf_pkg::*;

  cmd_t    f_cmd, q_cmd;
  logic    f_valid, f_ready;
  logic    q_valid, q_ready;
  result_t res;

  scf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .kind_i        (s_axis_tuser),
    .scan_code_i   (s_axis_tdata[7:0]),
    .upper_select_i(s_axis_tdata[8]),
    .entry_char_i  (s_axis_tdata[16:9]),
    .cmd_valid_o   (f_valid),
    .cmd_ready_i   (f_ready),
    .cmd_o         (f_cmd)
  );

  scf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_cmd_i   (f_cmd),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_cmd_o  (q_cmd)
  );

  scf_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_ready_o(q_ready),
    .cmd_i      (q_cmd),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = OUT_DATA_W'(res);

endmodule
`default_nettype wire

FILE: rtl/scf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scf_checker: result port checks
// Checks the consistency of result words on the output port.
// ----------------------------------------------------------------------------
module scf_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [scf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result word changed while stalled.");

  a_read_or_produce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[17]))
    else $error("A word both read and produced a character.");

  a_read_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("Character reported without a completed read.");

  a_produced_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17] == (m_axis_tdata[16:9] != 8'd0))
    else $error("Produced flag disagrees with produced character.");

  a_drop_needs_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[17])
    else $error("Drop flagged without a produced character.");

endmodule

bind scancode_to_char_fifo scf_checker u_scf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

FILE: verif/tb_scancode_to_char_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scancode_to_char_fifo: self-checking testbench for the scancode decoder
// Feeds scancodes, keymap writes and character reads into the input stream.
// A scoreboard predicts each result word from its own copy of the keymaps,
// the shift counter and the character ring, then compares every field.
// ----------------------------------------------------------------------------
module tb_scancode_to_char_fifo;
  import scf_pkg::*;

  localparam int unsigned FIFO_SLOTS     = 256;
  localparam int unsigned KEYMAP_ENTRIES = 128;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned IDLE_PERCENT   = 35;
  localparam int unsigned MAX_REPORTS    = 50;
  localparam logic [7:0]  RELEASE_BIT    = 8'h80;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [USER_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  bit          no_idle     = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned stall_count = 0;

  class keyboard_scoreboard;
    logic [CHAR_W-1:0] lower_map [KEYMAP_ENTRIES];
    logic [CHAR_W-1:0] upper_map [KEYMAP_ENTRIES];
    logic [CHAR_W-1:0] char_ring [FIFO_SLOTS];
    int unsigned       head;
    int unsigned       tail;
    logic [7:0]        shift_level;
    result_t           pending_char_words [$];
    int unsigned       errors;

    function new();
      foreach (lower_map[i]) begin
        lower_map[i] = '0;
        upper_map[i] = '0;
      end
      foreach (char_ring[i]) char_ring[i] = '0;
      head        = 0;
      tail        = 0;
      shift_level = '0;
      errors      = 0;
    endfunction

    function void take_key_word(kind_e kind, logic [7:0] code_byte, logic to_upper,
                                logic [CHAR_W-1:0] entry);
      result_t           want;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] ch;
      bit                is_shift;
      want     = '0;
      code     = code_byte[CODE_W-1:0];
      is_shift = (code == SCAN_SHIFT_LEFT) || (code == SCAN_SHIFT_RIGHT);
      case (kind)
        KIND_SCAN: begin
          if ((code_byte & RELEASE_BIT) != 0) begin
            if (is_shift && shift_level != 0) shift_level--;
          end else if (is_shift) begin
            if (shift_level != SHIFT_MAX) shift_level++;
          end else begin
            if (code == SCAN_ENTER) ch = CH_ENTER;
            else if (code == SCAN_BACKSPACE) ch = CH_BACKSPACE;
            else if (code == SCAN_SPACE) ch = CH_SPACE;
            else if (shift_level != 0) ch = upper_map[code];
            else ch = lower_map[code];
            if (ch != 0) begin
              want.produced_char  = ch;
              want.produced_valid = 1'b1;
              if ((tail + 1) % FIFO_SLOTS == head) begin
                want.dropped = 1'b1;
              end else begin
                char_ring[tail] = ch;
                tail = (tail + 1) % FIFO_SLOTS;
              end
            end
          end
        end
        KIND_READ: begin
          if (tail != head) begin
            want.read_char  = char_ring[head];
            want.read_valid = 1'b1;
            head = (head + 1) % FIFO_SLOTS;
          end
        end
        KIND_WRITE: begin
          if (code_byte < KEYMAP_ENTRIES) begin
            if (to_upper) upper_map[code] = entry;
            else lower_map[code] = entry;
          end
        end
        default: ;
      endcase
      pending_char_words.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string field, logic [CHAR_W-1:0] got, logic [CHAR_W-1:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    task check_char_word(logic [OUT_DATA_W-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[$bits(result_t)-1:0]);
      if (pending_char_words.size() == 0) begin
        report($sformatf("result word %0h arrived with nothing outstanding", word));
      end else begin
        want = pending_char_words.pop_front();
        compare_field("read_char", got.read_char, want.read_char);
        compare_field("read_valid", got.read_valid, want.read_valid);
        compare_field("produced_char", got.produced_char, want.produced_char);
        compare_field("produced_valid", got.produced_valid, want.produced_valid);
        compare_field("dropped", got.dropped, want.dropped);
      end
    endtask
  endclass

  keyboard_scoreboard kbd_check;

  scancode_to_char_fifo #(
    .FIFO_DEPTH(FIFO_SLOTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        kbd_check.take_key_word(kind_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[8],
                                s_axis_tdata[16:9]);
      end
      if (m_axis_tvalid && m_axis_tready) kbd_check.check_char_word(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  task automatic send_word(kind_e kind, logic [7:0] code_byte, logic to_upper,
                           logic [CHAR_W-1:0] entry);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= IN_DATA_W'({entry, to_upper, code_byte});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_scan(logic [7:0] code_byte);
    send_word(KIND_SCAN, code_byte, 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  task automatic send_read();
    send_word(KIND_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
              8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (kbd_check.pending_char_words.size() != 0);
  endtask

  function automatic logic [7:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(15);
    if (roll == 0) return {1'b0, SCAN_ENTER};
    if (roll == 1) return {1'b0, SCAN_SPACE};
    if (roll == 2) return {1'b0, SCAN_BACKSPACE};
    return {1'b0, CODE_W'($urandom_range(127))};
  endfunction

  function automatic logic [7:0] pick_shift();
    return {1'b0, ($urandom_range(1) != 0) ? SCAN_SHIFT_LEFT : SCAN_SHIFT_RIGHT};
  endfunction

  initial begin
    int unsigned roll;
    logic [7:0]  code_byte;
    kbd_check = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: empty read, unused kind, keymap edges, fixed keys, shift.
    send_word(KIND_READ, 8'h00, 1'b0, 8'h00);
    send_word(KIND_NOP, 8'hFF, 1'b1, 8'hFF);
    send_scan(8'h05);
    send_word(KIND_WRITE, 8'h00, 1'b0, 8'hFF);
    send_word(KIND_WRITE, 8'h7F, 1'b0, 8'h01);
    send_word(KIND_WRITE, 8'h7F, 1'b1, 8'hFF);
    send_word(KIND_WRITE, 8'h00, 1'b1, 8'h80);
    send_word(KIND_WRITE, 8'h80, 1'b0, 8'h55);
    send_word(KIND_WRITE, 8'hFF, 1'b1, 8'hAA);
    send_scan(8'h00);
    send_scan(8'h7F);
    send_scan(8'h80);
    send_scan(8'hFF);
    send_scan({1'b0, SCAN_ENTER});
    send_scan({1'b0, SCAN_BACKSPACE});
    send_scan({1'b0, SCAN_SPACE});
    send_scan(RELEASE_BIT | {1'b0, SCAN_SHIFT_LEFT});
    send_scan({1'b0, SCAN_SHIFT_LEFT});
    send_scan(8'h7F);
    send_scan({1'b0, SCAN_SHIFT_RIGHT});
    send_scan(RELEASE_BIT | {1'b0, SCAN_SHIFT_LEFT});
    send_scan(8'h00);
    send_scan(RELEASE_BIT | {1'b0, SCAN_SHIFT_RIGHT});
    send_scan(8'h00);
    repeat (9) send_read();
    wait_drained();

    // Full keymap load with neither side idling.
    no_idle = 1'b1;
    for (int i = 0; i < 2 * KEYMAP_ENTRIES; i++) begin
      code_byte = ($urandom_range(31) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_word(KIND_WRITE, 8'(i % KEYMAP_ENTRIES), 1'(i / KEYMAP_ENTRIES), code_byte);
    end
    wait_drained();
    no_idle = 1'b0;

    // Typing burst against a stalled receiver: fills the ring and drops.
    hold_req = 1'b1;
    for (int i = 0; i < 280; i++) send_scan(pick_key());
    wait_drained();
    for (int i = 0; i < 265; i++) send_read();
    wait_drained();

    // Shift counter driven to saturation and back down to zero, where it holds.
    for (int i = 0; i < 260; i++) begin
      send_scan(pick_shift());
      if ($urandom_range(15) == 0) send_scan(pick_key());
    end
    for (int i = 0; i < 262; i++) begin
      send_scan(RELEASE_BIT | pick_shift());
      if ($urandom_range(15) == 0) send_scan(pick_key());
      if ($urandom_range(31) == 0) send_read();
    end
    wait_drained();

    // Mixed traffic over the whole input space.
    for (int i = 0; i < 300; i++) begin
      roll      = $urandom_range(99);
      code_byte = 8'($urandom_range(255));
      if (roll < 50) begin
        send_scan(code_byte);
      end else if (roll < 85) begin
        send_word(KIND_READ, code_byte, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end else if (roll < 95) begin
        send_word(KIND_WRITE, code_byte, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        send_word(KIND_NOP, code_byte, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (kbd_check.errors == 0 && kbd_check.pending_char_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
